// File: rtl/core/cts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package cts_pkg;

   // scanner state between characters
   typedef enum logic [1:0] {
      MODE_IDLE,
      MODE_NUMBER,
      MODE_IDENT,
      MODE_ERROR
   } scan_mode_type;

   // token kinds as seen on the result channel
   typedef enum logic [3:0] {
      KIND_NUMBER = 4'd0,
      KIND_IDENT  = 4'd1,
      KIND_RETURN = 4'd2,
      KIND_INT    = 4'd3,
      KIND_VOID   = 4'd4,
      KIND_LBRACE = 4'd5,
      KIND_RBRACE = 4'd6,
      KIND_LPAREN = 4'd7,
      KIND_RPAREN = 4'd8,
      KIND_SEMI   = 4'd9,
      KIND_END    = 4'd10,
      KIND_ERROR  = 4'd11
   } token_kind_type;

   // character codes
   localparam logic [7:0] CHAR_TAB        = 8'h09;
   localparam logic [7:0] CHAR_NEWLINE    = 8'h0A;
   localparam logic [7:0] CHAR_SPACE      = 8'h20;
   localparam logic [7:0] CHAR_LPAREN     = 8'h28;
   localparam logic [7:0] CHAR_RPAREN     = 8'h29;
   localparam logic [7:0] CHAR_SEMI       = 8'h3B;
   localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
   localparam logic [7:0] CHAR_LBRACE     = 8'h7B;
   localparam logic [7:0] CHAR_RBRACE     = 8'h7D;

   // keywords, first character in the top byte
   localparam int KW_BUF_DEPTH = 6;
   localparam logic [5:0][7:0] KW_RETURN = "return";
   localparam logic [2:0][7:0] KW_INT    = "int";
   localparam logic [3:0][7:0] KW_VOID   = "void";

   // register file
   localparam int CSR_ADDR_WIDTH = 2;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int CFG_LINE_WIDTH = 16;
   localparam logic [CSR_ADDR_WIDTH-1:0] ADDR_FIRST_LINE = 2'd0;
   localparam logic [CFG_LINE_WIDTH-1:0] FIRST_LINE_RESET = 16'd1;

   // result pair queue, depth a power of two so pointers wrap
   localparam int QUEUE_DEPTH = 4;

   // configuration seen by the front end
   typedef struct packed {
      logic                      write;
      logic [CFG_LINE_WIDTH-1:0] value;
      logic [CFG_LINE_WIDTH-1:0] first_line;
   } cfg_ctl_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
             (c == CHAR_UNDERSCORE);
   endfunction

endpackage
`default_nettype wire

// File: rtl/core/cts_req_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface cts_req_if;
   logic       valid;
   logic       ready;
   logic       mode;
   logic [7:0] char_code;

   modport source (output valid, mode, char_code, input ready);
   modport sink (input valid, mode, char_code, output ready);
endinterface
`default_nettype wire

// File: rtl/core/cts_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface cts_rsp_if #(
   parameter int POSITION_WIDTH = 32,
   parameter int LINE_WIDTH     = 16,
   parameter int LENGTH_WIDTH   = 8
);
   logic                      valid;
   logic                      ready;
   logic [3:0]                token_kind;
   logic [POSITION_WIDTH-1:0] token_start;
   logic [LENGTH_WIDTH-1:0]   token_length;
   logic [LINE_WIDTH-1:0]     token_line;
   logic [7:0]                bad_char;
   logic                      last_result;

   modport source (output valid, token_kind, token_start, token_length, token_line,
                   bad_char, last_result, input ready);
   modport sink (input valid, token_kind, token_start, token_length, token_line,
                 bad_char, last_result, output ready);
endinterface
`default_nettype wire

// File: rtl/core/cts_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module cts_queue #(
   parameter int WIDTH = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic             pop,
   output logic      [WIDTH-1:0] rdata,
   output logic                  full,
   output logic                  empty
);
   import cts_pkg::*;

   localparam int PTR_WIDTH = $clog2(QUEUE_DEPTH);
   localparam int CNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   logic [WIDTH-1:0]     entry_ff [QUEUE_DEPTH];
   logic [PTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_WIDTH-1:0] count_ff, count_in;

   assign full  = (count_ff == CNT_WIDTH'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign rdata = entry_ff[rd_ptr_ff];

   // pointer and fill level update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + PTR_WIDTH'(1);
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + PTR_WIDTH'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_WIDTH'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= wdata;
      end
   end
endmodule
`default_nettype wire

// File: rtl/core/cts_front.sv
`timescale 1ns / 1ps
`default_nettype none
module cts_front #(
   parameter int POSITION_WIDTH = 32,
   parameter int LINE_WIDTH     = 16,
   parameter int LENGTH_WIDTH   = 8,
   localparam int PAIR_WIDTH = 1 + 2 * (12 + POSITION_WIDTH + LENGTH_WIDTH + LINE_WIDTH)
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   cts_req_if.sink                     req_ch,
   input  wire cts_pkg::cfg_ctl_type   cfg,
   input  wire logic                   q_full,
   output logic                        push,
   output logic [PAIR_WIDTH-1:0]       pair_data
);
   import cts_pkg::*;

   typedef struct packed {
      token_kind_type            kind;
      logic [POSITION_WIDTH-1:0] start;
      logic [LENGTH_WIDTH-1:0]   length;
      logic [LINE_WIDTH-1:0]     line;
      logic [7:0]                bad;
   } result_type;

   typedef struct packed {
      logic       two;
      result_type second;
      result_type first;
   } pair_type;

   localparam logic [LENGTH_WIDTH-1:0] LEN_MAX = '1;

   scan_mode_type             mode_ff, mode_in;
   logic [POSITION_WIDTH-1:0] pos_ff, pos_in;
   logic [POSITION_WIDTH-1:0] start_ff, start_in;
   logic [LENGTH_WIDTH-1:0]   len_ff, len_in;
   logic [LINE_WIDTH-1:0]     line_ff, line_in;
   logic [7:0]                kbuf_ff [KW_BUF_DEPTH];

   logic       accept;
   logic [7:0] c;
   logic       extend;
   logic       pending;
   logic       kbuf_we;
   logic [2:0] kbuf_idx;
   logic       match_return, match_int, match_void;
   logic       tok_valid;
   result_type flush_res, tok_res, end_res;
   pair_type   pair;

   assign req_ch.ready = !q_full;
   assign accept       = req_ch.valid && !q_full;
   assign c            = req_ch.char_code;

   // current character continues the pending number or identifier
   assign extend  = ((mode_ff == MODE_NUMBER) && is_digit(c)) ||
                    ((mode_ff == MODE_IDENT) && is_alpha(c));
   assign pending = (mode_ff == MODE_NUMBER) || (mode_ff == MODE_IDENT);

   // keyword match against the buffered leading characters
   always_comb begin
      match_return = (len_ff == LENGTH_WIDTH'(6));
      match_int    = (len_ff == LENGTH_WIDTH'(3));
      match_void   = (len_ff == LENGTH_WIDTH'(4));
      for (int i = 0; i < 6; i++) begin
         match_return = match_return && (kbuf_ff[i] == KW_RETURN[5-i]);
      end
      for (int i = 0; i < 3; i++) begin
         match_int = match_int && (kbuf_ff[i] == KW_INT[2-i]);
      end
      for (int i = 0; i < 4; i++) begin
         match_void = match_void && (kbuf_ff[i] == KW_VOID[3-i]);
      end
   end

   // finished number or word
   always_comb begin
      flush_res.start  = start_ff;
      flush_res.length = len_ff;
      flush_res.line   = line_ff;
      flush_res.bad    = '0;
      if (mode_ff == MODE_NUMBER) begin
         flush_res.kind = KIND_NUMBER;
      end else if (match_return) begin
         flush_res.kind = KIND_RETURN;
      end else if (match_int) begin
         flush_res.kind = KIND_INT;
      end else if (match_void) begin
         flush_res.kind = KIND_VOID;
      end else begin
         flush_res.kind = KIND_IDENT;
      end
   end

   // end of input marker
   always_comb begin
      end_res.kind   = KIND_END;
      end_res.start  = pos_ff;
      end_res.length = '0;
      end_res.line   = line_ff;
      end_res.bad    = '0;
   end

   // single character token or error
   always_comb begin
      tok_valid      = 1'b0;
      tok_res.kind   = KIND_ERROR;
      tok_res.start  = pos_ff;
      tok_res.length = LENGTH_WIDTH'(1);
      tok_res.line   = line_ff;
      tok_res.bad    = '0;
      unique case (c) inside
         CHAR_TAB, CHAR_SPACE, CHAR_NEWLINE: begin
            tok_valid = 1'b0;
         end
         CHAR_LBRACE: begin
            tok_valid    = 1'b1;
            tok_res.kind = KIND_LBRACE;
         end
         CHAR_RBRACE: begin
            tok_valid    = 1'b1;
            tok_res.kind = KIND_RBRACE;
         end
         CHAR_LPAREN: begin
            tok_valid    = 1'b1;
            tok_res.kind = KIND_LPAREN;
         end
         CHAR_RPAREN: begin
            tok_valid    = 1'b1;
            tok_res.kind = KIND_RPAREN;
         end
         CHAR_SEMI: begin
            tok_valid    = 1'b1;
            tok_res.kind = KIND_SEMI;
         end
         default: begin
            if (!is_digit(c) && !is_alpha(c)) begin
               tok_valid   = 1'b1;
               tok_res.bad = c;
            end
         end
      endcase
   end

   // next scan mode
   always_comb begin
      mode_in = mode_ff;
      if (accept) begin
         if (req_ch.mode) begin
            mode_in = MODE_IDLE;
         end else if (mode_ff == MODE_ERROR || extend) begin
            mode_in = mode_ff;
         end else if (is_digit(c)) begin
            mode_in = MODE_NUMBER;
         end else if (is_alpha(c)) begin
            mode_in = MODE_IDENT;
         end else if (tok_valid && tok_res.kind == KIND_ERROR) begin
            mode_in = MODE_ERROR;
         end else begin
            mode_in = MODE_IDLE;
         end
      end
   end

   // counters, buffer writes and result pair
   always_comb begin
      pos_in      = pos_ff;
      start_in    = start_ff;
      len_in      = len_ff;
      line_in     = line_ff;
      kbuf_we     = 1'b0;
      kbuf_idx    = len_ff[2:0];
      push        = 1'b0;
      pair.two    = 1'b0;
      pair.first  = flush_res;
      pair.second = tok_res;
      if (accept) begin
         if (req_ch.mode) begin
            // flush, end token, back to the start of a new input
            push = 1'b1;
            if (pending) begin
               pair.two    = 1'b1;
               pair.second = end_res;
            end else begin
               pair.first = end_res;
            end
            pos_in   = '0;
            start_in = '0;
            len_in   = '0;
            line_in  = LINE_WIDTH'(cfg.first_line);
         end else begin
            pos_in = pos_ff + POSITION_WIDTH'(1);
            if (mode_ff == MODE_ERROR) begin
               push = 1'b0;
            end else if (extend) begin
               kbuf_we = (mode_ff == MODE_IDENT) && (len_ff < LENGTH_WIDTH'(KW_BUF_DEPTH));
               if (len_ff != LEN_MAX) begin
                  len_in = len_ff + LENGTH_WIDTH'(1);
               end
            end else begin
               if (c == CHAR_NEWLINE) begin
                  line_in = line_ff + LINE_WIDTH'(1);
               end
               if (is_digit(c) || is_alpha(c)) begin
                  start_in = pos_ff;
                  len_in   = LENGTH_WIDTH'(1);
                  kbuf_we  = is_alpha(c);
                  kbuf_idx = '0;
               end
               push = pending || tok_valid;
               if (pending) begin
                  pair.two = tok_valid;
               end else begin
                  pair.first = tok_res;
               end
            end
         end
      end else if (cfg.write && (pos_ff == '0) && (mode_ff == MODE_IDLE)) begin
         line_in = LINE_WIDTH'(cfg.value);
      end
   end

   assign pair_data = pair;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         pos_ff   <= '0;
         start_ff <= '0;
         len_ff   <= '0;
         line_ff  <= LINE_WIDTH'(FIRST_LINE_RESET);
      end else begin
         mode_ff  <= mode_in;
         pos_ff   <= pos_in;
         start_ff <= start_in;
         len_ff   <= len_in;
         line_ff  <= line_in;
      end
   end

   // leading characters of an identifier, only read once written
   always_ff @(posedge clock) begin
      if (kbuf_we) begin
         kbuf_ff[kbuf_idx] <= c;
      end
   end
endmodule
`default_nettype wire

// File: rtl/core/cts_back.sv
`timescale 1ns / 1ps
`default_nettype none
module cts_back #(
   parameter int POSITION_WIDTH = 32,
   parameter int LINE_WIDTH     = 16,
   parameter int LENGTH_WIDTH   = 8,
   localparam int PAIR_WIDTH = 1 + 2 * (12 + POSITION_WIDTH + LENGTH_WIDTH + LINE_WIDTH)
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [PAIR_WIDTH-1:0] pair_data,
   input  wire logic                  q_empty,
   output logic                       pop,
   cts_rsp_if.source                  rsp_ch
);
   import cts_pkg::*;

   typedef struct packed {
      token_kind_type            kind;
      logic [POSITION_WIDTH-1:0] start;
      logic [LENGTH_WIDTH-1:0]   length;
      logic [LINE_WIDTH-1:0]     line;
      logic [7:0]                bad;
   } result_type;

   typedef struct packed {
      logic       two;
      result_type second;
      result_type first;
   } pair_type;

   pair_type   pair_ff;
   logic       valid_ff, valid_in;
   logic       sel_ff, sel_in;
   logic       last;
   logic       taken;
   logic       load;
   result_type cur;

   assign last  = sel_ff || !pair_ff.two;
   assign taken = valid_ff && rsp_ch.ready;
   assign load  = !valid_ff || (taken && last);
   assign pop   = load && !q_empty;
   assign cur   = sel_ff ? pair_ff.second : pair_ff.first;

   // result channel driven from the held pair
   assign rsp_ch.valid        = valid_ff;
   assign rsp_ch.token_kind   = cur.kind;
   assign rsp_ch.token_start  = cur.start;
   assign rsp_ch.token_length = cur.length;
   assign rsp_ch.token_line   = cur.line;
   assign rsp_ch.bad_char     = cur.bad;
   assign rsp_ch.last_result  = last;

   // step through the pair, refill when the last item leaves or none is held
   always_comb begin
      valid_in = valid_ff;
      sel_in   = sel_ff;
      if (load) begin
         valid_in = !q_empty;
         sel_in   = 1'b0;
      end else if (taken) begin
         sel_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sel_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         sel_ff   <= sel_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         pair_ff <= pair_data;
      end
   end
endmodule
`default_nettype wire

// File: rtl/core/c_subset_token_scanner.sv
`timescale 1ns / 1ps
`default_nettype none
// Token scanner for a small C subset. One source character (or an end of input marker)
// is taken per cycle on req_ch unless the queue is full; the front end classifies it
// that cycle and posts the one or two tokens it completes as a pair into a four deep
// queue, and the output stage hands them out on rsp_ch one item per cycle while rsp_ch
// is ready. A character that ends a token and forms a second one yields two items; the
// queue depth sets how long a stalled result side is hidden from the input. Results
// pass the queue and the output stage's pair register. Tokens are given as kind, start
// offset, length (saturating) and line; first_line (offset 0) sets the line number of
// a new input and takes effect at once while no character has been scanned.
module c_subset_token_scanner #(
   parameter int POSITION_WIDTH = 32,
   parameter int LINE_WIDTH     = 16,
   parameter int LENGTH_WIDTH   = 8
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   cts_req_if.sink                                  req_ch,
   cts_rsp_if.source                                rsp_ch,
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [cts_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  wire logic [cts_pkg::CSR_DATA_WIDTH-1:0]  csr_pwdata,
   output logic      [cts_pkg::CSR_DATA_WIDTH-1:0]  csr_prdata,
   output logic                                     csr_pready
);
   import cts_pkg::*;

   localparam int PAIR_WIDTH = 1 + 2 * (12 + POSITION_WIDTH + LENGTH_WIDTH + LINE_WIDTH);

   logic [CFG_LINE_WIDTH-1:0] first_line_ff, first_line_in;
   logic                      csr_write;
   cfg_ctl_type               cfg;
   logic                      q_push, q_pop, q_full, q_empty;
   logic [PAIR_WIDTH-1:0]     q_wdata, q_rdata;

   // register port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite &&
                       (csr_paddr == ADDR_FIRST_LINE);
   assign csr_prdata = (csr_paddr == ADDR_FIRST_LINE) ?
                       CSR_DATA_WIDTH'(first_line_ff) : '0;

   always_comb begin
      first_line_in = first_line_ff;
      if (csr_write) begin
         first_line_in = csr_pwdata[CFG_LINE_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_line_ff <= FIRST_LINE_RESET;
      end else begin
         first_line_ff <= first_line_in;
      end
   end

   assign cfg.write      = csr_write;
   assign cfg.value      = csr_pwdata[CFG_LINE_WIDTH-1:0];
   assign cfg.first_line = first_line_ff;

   // character classification and scanner state
   cts_front #(
      .POSITION_WIDTH (POSITION_WIDTH),
      .LINE_WIDTH     (LINE_WIDTH),
      .LENGTH_WIDTH   (LENGTH_WIDTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .cfg       (cfg),
      .q_full    (q_full),
      .push      (q_push),
      .pair_data (q_wdata)
   );

   // result pairs between front and back
   cts_queue #(
      .WIDTH (PAIR_WIDTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .wdata (q_wdata),
      .pop   (q_pop),
      .rdata (q_rdata),
      .full  (q_full),
      .empty (q_empty)
   );

   // output stage
   cts_back #(
      .POSITION_WIDTH (POSITION_WIDTH),
      .LINE_WIDTH     (LINE_WIDTH),
      .LENGTH_WIDTH   (LENGTH_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pair_data (q_rdata),
      .q_empty   (q_empty),
      .pop       (q_pop),
      .rsp_ch    (rsp_ch)
   );
endmodule
`default_nettype wire
